FILE: rtl/core/pcsm_pkg.sv
// Shared types, constants and helpers for the P-code stack machine.
// No dependencies; used by every module of the block.
`default_nettype none

package pcsm_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 512;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int SPW         = $clog2(STACK_DEPTH + 1);

    // Opcodes.
    localparam logic [3:0] OP_NOP = 4'd0;
    localparam logic [3:0] OP_LIT = 4'd1;
    localparam logic [3:0] OP_OPR = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_STO = 4'd4;
    localparam logic [3:0] OP_CAL = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JPC = 4'd8;
    localparam logic [3:0] OP_SYS = 4'd9;

    // OPR function codes.
    localparam logic [3:0] FN_ADD = 4'd1;
    localparam logic [3:0] FN_SUB = 4'd2;
    localparam logic [3:0] FN_MUL = 4'd3;
    localparam logic [3:0] FN_DIV = 4'd4;
    localparam logic [3:0] FN_EQ  = 4'd5;
    localparam logic [3:0] FN_NE  = 4'd6;
    localparam logic [3:0] FN_LT  = 4'd7;
    localparam logic [3:0] FN_LE  = 4'd8;
    localparam logic [3:0] FN_GT  = 4'd9;
    localparam logic [3:0] FN_GE  = 4'd10;

    // SYS function codes.
    localparam logic [31:0] SYS_OUT  = 32'd1;
    localparam logic [31:0] SYS_IN   = 32'd2;
    localparam logic [31:0] SYS_HALT = 32'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_OPC   = 3'd1;
    localparam logic [2:0] ERR_FUNC  = 3'd2;
    localparam logic [2:0] ERR_DIV0  = 3'd3;
    localparam logic [2:0] ERR_RANGE = 3'd4;

    // Instruction classes produced by the front end.
    localparam logic [3:0] CL_NOP   = 4'd0;
    localparam logic [3:0] CL_LIT   = 4'd1;
    localparam logic [3:0] CL_RET   = 4'd2;
    localparam logic [3:0] CL_ARITH = 4'd3;
    localparam logic [3:0] CL_LOD   = 4'd4;
    localparam logic [3:0] CL_STO   = 4'd5;
    localparam logic [3:0] CL_CAL   = 4'd6;
    localparam logic [3:0] CL_INC   = 4'd7;
    localparam logic [3:0] CL_JMP   = 4'd8;
    localparam logic [3:0] CL_JPC   = 4'd9;
    localparam logic [3:0] CL_OUT   = 4'd10;
    localparam logic [3:0] CL_IN    = 4'd11;
    localparam logic [3:0] CL_HALT  = 4'd12;
    localparam logic [3:0] CL_ERR   = 4'd13;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [3:0]         level;
        logic signed [31:0] operand;
        logic signed [31:0] in_value;
    } t_in;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               halted;
        logic [2:0]         error_code;
    } t_out;

    // Classified instruction carried from front to back.
    typedef struct packed {
        logic [3:0]  cls;
        logic [3:0]  fn;
        logic [3:0]  level;
        logic [31:0] operand;
        logic [31:0] in_value;
        logic [2:0]  err;
    } t_cmd;

    // True when a signed 34-bit value is a valid stack index.
    function automatic logic idx_ok(input logic [33:0] a);
        return !a[33] && (a[32:0] < 33'(STACK_DEPTH));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcsm_front.sv
// Front end: accepts instructions and classifies them for the back end.
// Depends on pcsm_pkg.
`default_nettype none

module pcsm_front (
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  pcsm_pkg::t_in    i_in_data,
    input  wire              i_clearing,
    input  wire              i_q_full,
    output logic             o_push,
    output pcsm_pkg::t_cmd   o_cmd
);
    import pcsm_pkg::*;

    logic fn_ok;

    // Accept only when the queue has room and the stack clear is over.
    assign o_in_ready = !i_q_full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    assign fn_ok = (i_in_data.operand[31:4] == 28'd0) && (i_in_data.operand[3:0] != 4'd0)
                   && (i_in_data.operand[3:0] <= FN_GE);

    // Classify the opcode and catch the static errors.
    always_comb begin
        o_cmd.cls      = CL_ERR;
        o_cmd.fn       = i_in_data.operand[3:0];
        o_cmd.level    = i_in_data.level;
        o_cmd.operand  = i_in_data.operand;
        o_cmd.in_value = i_in_data.in_value;
        o_cmd.err      = ERR_NONE;
        case (i_in_data.opcode)
            OP_NOP: o_cmd.cls = CL_NOP;
            OP_LIT: o_cmd.cls = CL_LIT;
            OP_OPR: begin
                if (i_in_data.operand == 32'sd0) begin
                    o_cmd.cls = CL_RET;
                end else if (fn_ok) begin
                    o_cmd.cls = CL_ARITH;
                end else begin
                    o_cmd.err = ERR_FUNC;
                end
            end
            OP_LOD: o_cmd.cls = CL_LOD;
            OP_STO: o_cmd.cls = CL_STO;
            OP_CAL: o_cmd.cls = CL_CAL;
            OP_INC: o_cmd.cls = CL_INC;
            OP_JMP: o_cmd.cls = CL_JMP;
            OP_JPC: o_cmd.cls = CL_JPC;
            OP_SYS: begin
                if (i_in_data.operand == SYS_OUT) begin
                    o_cmd.cls = CL_OUT;
                end else if (i_in_data.operand == SYS_IN) begin
                    o_cmd.cls = CL_IN;
                end else if (i_in_data.operand == SYS_HALT) begin
                    o_cmd.cls = CL_HALT;
                end else begin
                    o_cmd.err = ERR_FUNC;
                end
            end
            default: o_cmd.err = ERR_OPC;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_queue.sv
// Two-entry queue of classified instructions between front and back.
// Depends on pcsm_pkg.
`default_nettype none

module pcsm_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  pcsm_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output pcsm_pkg::t_cmd  o_cmd
);
    import pcsm_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_buf[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_div.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// Depends on pcsm_pkg only for the house import convention.
`default_nettype none

module pcsm_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_dividend,
    input  wire  [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import pcsm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted    = {r_rem[31:0], r_quo[31]};
    assign diff       = shifted - {1'b0, r_dvs};
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 33'd0;
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_dvs <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= diff[32] ? shifted : diff;
            r_quo <= {r_quo[30:0], !diff[32]};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_back.sv
// Back end: sequencer that executes classified instructions on the stack memory.
// Depends on pcsm_pkg and pcsm_div.
`default_nettype none

module pcsm_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_valid,
    input  pcsm_pkg::t_cmd  i_q_cmd,
    output logic            o_pop,
    output logic            o_clearing,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output pcsm_pkg::t_out  o_out_data
);
    import pcsm_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_WALK    = 4'd1;
    localparam logic [3:0] ST_WALK_WT = 4'd2;
    localparam logic [3:0] ST_EXEC    = 4'd3;
    localparam logic [3:0] ST_RET1    = 4'd4;
    localparam logic [3:0] ST_RET2    = 4'd5;
    localparam logic [3:0] ST_AR1     = 4'd6;
    localparam logic [3:0] ST_AR2     = 4'd7;
    localparam logic [3:0] ST_AR3     = 4'd8;
    localparam logic [3:0] ST_DIV     = 4'd9;
    localparam logic [3:0] ST_WRR     = 4'd10;
    localparam logic [3:0] ST_RD1     = 4'd11;
    localparam logic [3:0] ST_CAL2    = 4'd12;
    localparam logic [3:0] ST_CAL3    = 4'd13;

    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rd;
    logic [SPW-1:0] r_clr;

    logic [3:0]     r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    logic [3:0]     r_lv, n_lv;
    logic [31:0]    r_b, n_b;
    logic [31:0]    r_x, n_x;
    logic [31:0]    r_y, n_y;
    logic [31:0]    r_res, n_res;
    logic [AW-1:0]  r_addr, n_addr;
    logic [SPW-1:0] r_sp, n_sp;
    logic [SPW-1:0] r_bp, n_bp;
    logic [15:0]    r_pc, n_pc;
    logic           r_halt, n_halt;
    logic           r_ov;
    t_out           r_out;

    logic           done;
    logic [2:0]     d_err;
    logic           d_ov;
    logic [31:0]    d_oval;
    logic           re;
    logic [AW-1:0]  ra;
    logic           we;
    logic [AW-1:0]  wa;
    logic [31:0]    wd;
    logic           div_start;
    logic           div_done;
    logic [31:0]    div_q;
    logic [31:0]    alu;
    logic [31:0]    prod;
    logic [15:0]    pc3;
    logic           m_ok;
    logic [33:0]    fr_addr;
    logic [33:0]    inc_sp;
    logic [SPW-1:0] sp_m1, sp_m2, sp_m3, sp_p1, bp_m1, bp_m2, bp_p1;

    assign o_clearing  = (r_clr != SPW'(STACK_DEPTH));
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign pc3   = r_pc + 16'd3;
    assign m_ok  = (r_cmd.operand[31:16] == 16'd0);
    assign sp_m1 = r_sp - SPW'(1);
    assign sp_m2 = r_sp - SPW'(2);
    assign sp_m3 = r_sp - SPW'(3);
    assign sp_p1 = r_sp + SPW'(1);
    assign bp_m1 = r_bp - SPW'(1);
    assign bp_m2 = r_bp - SPW'(2);
    assign bp_p1 = r_bp + SPW'(1);
    assign fr_addr = {{2{r_b[31]}}, r_b} - {{2{r_cmd.operand[31]}}, r_cmd.operand};
    assign inc_sp  = {{(34 - SPW){1'b0}}, r_sp} - {{2{r_cmd.operand[31]}}, r_cmd.operand};
    assign prod    = r_x * r_y;

    pcsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Arithmetic and compare functions of OPR.
    always_comb begin
        case (r_cmd.fn)
            FN_ADD:  alu = r_x + r_y;
            FN_SUB:  alu = r_x - r_y;
            FN_MUL:  alu = prod;
            FN_EQ:   alu = 32'(r_x == r_y);
            FN_NE:   alu = 32'(r_x != r_y);
            FN_LT:   alu = 32'($signed(r_x) < $signed(r_y));
            FN_LE:   alu = 32'($signed(r_x) <= $signed(r_y));
            FN_GT:   alu = 32'($signed(r_x) > $signed(r_y));
            FN_GE:   alu = 32'($signed(r_x) >= $signed(r_y));
            default: alu = 32'd0;
        endcase
    end

    // Instruction sequencer.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_lv      = r_lv;
        n_b       = r_b;
        n_x       = r_x;
        n_y       = r_y;
        n_res     = r_res;
        n_addr    = r_addr;
        n_sp      = r_sp;
        n_bp      = r_bp;
        n_pc      = r_pc;
        n_halt    = r_halt;
        done      = 1'b0;
        d_err     = ERR_NONE;
        d_ov      = 1'b0;
        d_oval    = 32'd0;
        re        = 1'b0;
        ra        = '0;
        we        = 1'b0;
        wa        = '0;
        wd        = 32'd0;
        div_start = 1'b0;
        o_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!o_clearing && i_q_valid && !r_ov) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_cmd;
                    n_lv  = i_q_cmd.level;
                    n_b   = 32'(r_bp);
                    if (r_halt) begin
                        done = 1'b1;
                    end else if (i_q_cmd.cls == CL_LOD || i_q_cmd.cls == CL_STO
                                 || i_q_cmd.cls == CL_CAL) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_WALK: begin
                if (r_lv == 4'd0) begin
                    n_state = ST_EXEC;
                end else if (!idx_ok({{2{r_b[31]}}, r_b})) begin
                    done    = 1'b1;
                    d_err   = ERR_RANGE;
                    n_state = ST_IDLE;
                end else begin
                    re      = 1'b1;
                    ra      = r_b[AW-1:0];
                    n_state = ST_WALK_WT;
                end
            end
            ST_WALK_WT: begin
                n_b     = r_rd;
                n_lv    = r_lv - 4'd1;
                n_state = ST_WALK;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_cmd.cls)
                    CL_NOP: begin
                        done = 1'b1;
                        n_pc = pc3;
                    end
                    CL_LIT: begin
                        done = 1'b1;
                        if (r_sp != '0) begin
                            we   = 1'b1;
                            wa   = sp_m1[AW-1:0];
                            wd   = r_cmd.operand;
                            n_sp = sp_m1;
                            n_pc = pc3;
                        end else begin
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_RET: begin
                        if (r_bp >= SPW'(2)) begin
                            re      = 1'b1;
                            ra      = bp_m1[AW-1:0];
                            n_state = ST_RET1;
                        end else begin
                            done  = 1'b1;
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_ARITH: begin
                        if (r_sp <= SPW'(STACK_DEPTH - 2)) begin
                            re      = 1'b1;
                            ra      = r_sp[AW-1:0];
                            n_state = ST_AR1;
                        end else begin
                            done  = 1'b1;
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_LOD: begin
                        if (idx_ok(fr_addr) && r_sp != '0) begin
                            re      = 1'b1;
                            ra      = fr_addr[AW-1:0];
                            n_state = ST_RD1;
                        end else begin
                            done  = 1'b1;
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_STO: begin
                        if (idx_ok(fr_addr) && r_sp < SPW'(STACK_DEPTH)) begin
                            re      = 1'b1;
                            ra      = r_sp[AW-1:0];
                            n_addr  = fr_addr[AW-1:0];
                            n_state = ST_RD1;
                        end else begin
                            done  = 1'b1;
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_CAL: begin
                        if (r_sp >= SPW'(3) && m_ok) begin
                            we      = 1'b1;
                            wa      = sp_m1[AW-1:0];
                            wd      = r_b;
                            n_state = ST_CAL2;
                        end else begin
                            done  = 1'b1;
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_INC: begin
                        done = 1'b1;
                        if (!inc_sp[33] && inc_sp[32:0] <= 33'(STACK_DEPTH)) begin
                            n_sp = inc_sp[SPW-1:0];
                            n_pc = pc3;
                        end else begin
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_JMP: begin
                        done = 1'b1;
                        if (m_ok) begin
                            n_pc = r_cmd.operand[15:0];
                        end else begin
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_JPC, CL_OUT: begin
                        if (r_sp < SPW'(STACK_DEPTH) && (m_ok || r_cmd.cls == CL_OUT)) begin
                            re      = 1'b1;
                            ra      = r_sp[AW-1:0];
                            n_state = ST_RD1;
                        end else begin
                            done  = 1'b1;
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_IN: begin
                        done = 1'b1;
                        if (r_sp != '0) begin
                            we   = 1'b1;
                            wa   = sp_m1[AW-1:0];
                            wd   = r_cmd.in_value;
                            n_sp = sp_m1;
                            n_pc = pc3;
                        end else begin
                            d_err = ERR_RANGE;
                        end
                    end
                    CL_HALT: begin
                        done   = 1'b1;
                        n_halt = 1'b1;
                        n_pc   = pc3;
                    end
                    default: begin
                        done  = 1'b1;
                        d_err = r_cmd.err;
                    end
                endcase
            end
            ST_RET1: begin
                n_x     = r_rd;
                re      = 1'b1;
                ra      = bp_m2[AW-1:0];
                n_state = ST_RET2;
            end
            ST_RET2: begin
                done    = 1'b1;
                n_state = ST_IDLE;
                if (idx_ok({{2{r_x[31]}}, r_x}) && r_rd[31:16] == 16'd0) begin
                    n_sp = bp_p1;
                    n_bp = r_x[SPW-1:0];
                    n_pc = r_rd[15:0];
                end else begin
                    d_err = ERR_RANGE;
                end
            end
            ST_AR1: begin
                n_y     = r_rd;
                re      = 1'b1;
                ra      = sp_p1[AW-1:0];
                n_state = ST_AR2;
            end
            ST_AR2: begin
                n_x     = r_rd;
                n_state = ST_AR3;
            end
            ST_AR3: begin
                if (r_cmd.fn == FN_DIV) begin
                    if (r_y == 32'd0) begin
                        done    = 1'b1;
                        d_err   = ERR_DIV0;
                        n_state = ST_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end else begin
                    n_res   = alu;
                    n_state = ST_WRR;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_res   = div_q;
                    n_state = ST_WRR;
                end
            end
            ST_WRR: begin
                we      = 1'b1;
                wa      = sp_p1[AW-1:0];
                wd      = r_res;
                n_sp    = sp_p1;
                n_pc    = pc3;
                done    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RD1: begin
                done    = 1'b1;
                n_state = ST_IDLE;
                n_pc    = pc3;
                n_sp    = sp_p1;
                case (r_cmd.cls)
                    CL_LOD: begin
                        we   = 1'b1;
                        wa   = sp_m1[AW-1:0];
                        wd   = r_rd;
                        n_sp = sp_m1;
                    end
                    CL_STO: begin
                        we = 1'b1;
                        wa = r_addr;
                        wd = r_rd;
                    end
                    CL_JPC: begin
                        if (r_rd == 32'd0) begin
                            n_pc = r_cmd.operand[15:0];
                        end
                    end
                    default: begin
                        d_ov   = 1'b1;
                        d_oval = r_rd;
                    end
                endcase
            end
            ST_CAL2: begin
                we      = 1'b1;
                wa      = sp_m2[AW-1:0];
                wd      = 32'(r_bp);
                n_state = ST_CAL3;
            end
            ST_CAL3: begin
                we      = 1'b1;
                wa      = sp_m3[AW-1:0];
                wd      = {16'd0, pc3};
                n_bp    = sp_m1;
                n_pc    = r_cmd.operand[15:0];
                done    = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Architectural state, output register and clear sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sp    <= SPW'(STACK_DEPTH);
            r_bp    <= SPW'(STACK_DEPTH - 1);
            r_pc    <= 16'd0;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_bp    <= n_bp;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            if (o_clearing) begin
                r_clr <= r_clr + SPW'(1);
            end
            if (done) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_lv   <= n_lv;
        r_b    <= n_b;
        r_x    <= n_x;
        r_y    <= n_y;
        r_res  <= n_res;
        r_addr <= n_addr;
        if (done) begin
            r_out.next_pc    <= n_pc;
            r_out.out_valid  <= d_ov;
            r_out.out_value  <= d_oval;
            r_out.halted     <= n_halt;
            r_out.error_code <= d_err;
        end
    end

    // Stack memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (o_clearing) begin
            r_mem[r_clr[AW-1:0]] <= 32'd0;
        end else if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rd <= r_mem[ra];
        end
    end

`ifndef SYNTHESIS
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_pop)
        else $error("instruction taken during stack clear");
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_pc) && r_halt)
        else $error("state moved after halt");
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && d_err != ERR_NONE) |=> $stable(r_sp) && $stable(r_bp) && $stable(r_pc))
        else $error("faulting instruction changed state");
    a_bp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bp < SPW'(STACK_DEPTH) && r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointers out of range");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !done)
        else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pcode_stack_machine_execute.sv
// P-code stack machine: one instruction per input transaction, one result transaction each.
// NOP, LIT, INC, JMP, SYS input, halt and opcode faults finish without a stack read; JPC and
// SYS output read the top of stack, return two frame words, OPR arithmetic two operands, and
// divide then waits on the divider; LOD, STO and CAL first follow each static link in turn.
// Once halted it answers without executing; the next starts only after the result is taken.
// Synchronous active-low reset; the 512-entry stack clear after it accepts no transaction.
`default_nettype none

module pcode_stack_machine_execute (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  pcsm_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output pcsm_pkg::t_out  o_out_data
);
    import pcsm_pkg::*;

    logic clearing;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    pcsm_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    pcsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (q_cmd)
    );

    pcsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
